@@ hw/rtl/lifet_pkg.sv @@
// Shared types and constants for the toroidal Life engine.
`timescale 1ns / 1ps

package lifet_pkg;

  // Life rule neighbor counts
  localparam int unsigned NbrSurviveLo = 2;
  localparam int unsigned NbrBirth     = 3;
  localparam int unsigned NbrCntW      = 4;

  localparam int unsigned RowCellsW  = 16;
  localparam int unsigned RowIndexW  = 4;
  localparam int unsigned GenCountW  = 8;
  localparam int unsigned GenCountRst = 1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_EVOLVE,
    ST_EMIT
  } lifet_state_e;

  // Datapath commands; every active command rotates the row line by one row
  typedef struct packed {
    logic load;   // push the requested input row into the tail
    logic step;   // compute one next-generation row into the tail
    logic first;  // first row of a generation sweep
    logic last;   // last row of a generation sweep
    logic emit;   // rotate the head row back into the tail
  } lifet_cmd_t;

endpackage

@@ hw/rtl/lifet_datapath.sv @@
// Board row line and the shared one-row Life rule unit.
`timescale 1ns / 1ps

module lifet_datapath import lifet_pkg::*; #(
  parameter int unsigned BOARD_HEIGHT = 16,
  parameter int unsigned BOARD_WIDTH  = 16
) (
  input  logic                 clk_i,
  input  lifet_cmd_t           cmd_i,
  input  logic [RowCellsW-1:0] row_cells_i,
  output logic [RowCellsW-1:0] out_row_cells_o
);

  localparam int unsigned ExtW = (BOARD_WIDTH > RowCellsW) ? BOARD_WIDTH : RowCellsW;

  // board_q[0] is the head row; rows enter at the tail
  logic [BOARD_WIDTH-1:0] board_q [BOARD_HEIGHT];
  logic [BOARD_WIDTH-1:0] prev_q;
  logic [BOARD_WIDTH-1:0] first_q;

  logic [BOARD_WIDTH-1:0] load_row;
  logic [BOARD_WIDTH-1:0] up_row;
  logic [BOARD_WIDTH-1:0] mid_row;
  logic [BOARD_WIDTH-1:0] dn_row;
  logic [BOARD_WIDTH-1:0] next_row;
  logic [BOARD_WIDTH-1:0] tail_d;
  logic [ExtW-1:0]        in_ext;
  logic [ExtW-1:0]        out_ext;
  logic                   advance;

  assign in_ext   = ExtW'(row_cells_i);
  assign load_row = in_ext[BOARD_WIDTH-1:0];

  assign out_ext         = ExtW'(board_q[0]);
  assign out_row_cells_o = out_ext[RowCellsW-1:0];

  // The row above row 0 is the last row; the row below the last row is the
  // old row 0, saved at the start of the sweep.
  assign up_row  = cmd_i.first ? board_q[BOARD_HEIGHT-1] : prev_q;
  assign mid_row = board_q[0];
  assign dn_row  = cmd_i.last ? first_q : board_q[1];

  always_comb begin
    logic [NbrCntW-1:0] n;
    int unsigned lf;
    int unsigned rt;
    next_row = '0;
    for (int unsigned c = 0; c < BOARD_WIDTH; c++) begin
      lf = (c + BOARD_WIDTH - 1) % BOARD_WIDTH;
      rt = (c + 1) % BOARD_WIDTH;
      n = NbrCntW'(up_row[lf]) + NbrCntW'(up_row[c]) + NbrCntW'(up_row[rt])
        + NbrCntW'(mid_row[lf]) + NbrCntW'(mid_row[rt])
        + NbrCntW'(dn_row[lf]) + NbrCntW'(dn_row[c]) + NbrCntW'(dn_row[rt]);
      if (mid_row[c]) begin
        next_row[c] = (n == NbrCntW'(NbrSurviveLo)) || (n == NbrCntW'(NbrBirth));
      end else begin
        next_row[c] = (n == NbrCntW'(NbrBirth));
      end
    end
  end

  always_comb begin
    if (cmd_i.load) begin
      tail_d = load_row;
    end else if (cmd_i.step) begin
      tail_d = next_row;
    end else begin
      tail_d = board_q[0];
    end
  end

  assign advance = cmd_i.load | cmd_i.step | cmd_i.emit;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int unsigned i = 0; i + 1 < BOARD_HEIGHT; i++) begin
        board_q[i] <= board_q[i+1];
      end
      board_q[BOARD_HEIGHT-1] <= tail_d;
    end
    if (cmd_i.step) begin
      prev_q <= board_q[0];
      if (cmd_i.first) begin
        first_q <= board_q[0];
      end
    end
  end

endmodule

@@ hw/rtl/lifet_ctrl.sv @@
// Sequencer for load, evolve and emit phases of the Life engine.
`timescale 1ns / 1ps

module lifet_ctrl import lifet_pkg::*; #(
  parameter int unsigned BOARD_HEIGHT = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [GenCountW-1:0] gen_count_i,
  output logic                 busy_o,
  output lifet_cmd_t           cmd_o,
  output logic                 out_strobe_o,
  output logic [RowIndexW-1:0] out_row_index_o,
  output logic                 last_row_o
);

  localparam int unsigned RowW = $clog2(BOARD_HEIGHT);
  localparam int unsigned IdxW = (RowW > RowIndexW) ? RowW : RowIndexW;
  localparam logic [RowW-1:0] LastRow = RowW'(BOARD_HEIGHT - 1);

  lifet_state_e          state_q, state_d;
  logic [RowW-1:0]       row_cnt_q, row_cnt_d;
  logic [GenCountW-1:0]  gen_cnt_q, gen_cnt_d;
  logic                  row_last;
  logic                  gen_last;
  logic [IdxW-1:0]       idx_ext;

  assign row_last = (row_cnt_q == LastRow);
  assign gen_last = (({1'b0, gen_cnt_q} + (GenCountW+1)'(1)) == {1'b0, gen_count_i});

  assign idx_ext         = IdxW'(row_cnt_q);
  assign out_row_index_o = idx_ext[RowIndexW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      row_cnt_q <= '0;
      gen_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      row_cnt_q <= row_cnt_d;
      gen_cnt_q <= gen_cnt_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    row_cnt_d    = row_cnt_q;
    gen_cnt_d    = gen_cnt_q;
    cmd_o        = '0;
    busy_o       = 1'b1;
    out_strobe_o = 1'b0;
    last_row_o   = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (row_last) begin
            row_cnt_d = '0;
            state_d   = (gen_count_i == '0) ? ST_EMIT : ST_EVOLVE;
          end else begin
            row_cnt_d = row_cnt_q + RowW'(1);
          end
        end
      end
      ST_EVOLVE: begin
        cmd_o.step  = 1'b1;
        cmd_o.first = (row_cnt_q == '0);
        cmd_o.last  = row_last;
        if (row_last) begin
          row_cnt_d = '0;
          if (gen_last) begin
            gen_cnt_d = '0;
            state_d   = ST_EMIT;
          end else begin
            gen_cnt_d = gen_cnt_q + GenCountW'(1);
          end
        end else begin
          row_cnt_d = row_cnt_q + RowW'(1);
        end
      end
      ST_EMIT: begin
        cmd_o.emit   = 1'b1;
        out_strobe_o = 1'b1;
        last_row_o   = row_last;
        if (row_last) begin
          row_cnt_d = '0;
          state_d   = ST_LOAD;
        end else begin
          row_cnt_d = row_cnt_q + RowW'(1);
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

@@ hw/rtl/life_automaton_torus_unit.sv @@
// Top level of the toroidal Game of Life engine.
`timescale 1ns / 1ps

// Load a board one row per request (start_i while busy_o is low, row 0 first).
// After the last row busy_o rises and the block runs generation_count
// generations through a single row-wide rule unit, one row per cycle. The
// final board then leaves one row per cycle, each row marked by out_strobe_o
// and the final one by last_row_o; the receiver cannot stall, so it must take
// every strobed row. The generation count register is written through the cfg
// channel (always ready); the user must write it only while idle, as the block
// itself does not enforce this.
module life_automaton_torus_unit import lifet_pkg::*; #(
  parameter int unsigned BOARD_HEIGHT = 16,
  parameter int unsigned BOARD_WIDTH  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [RowCellsW-1:0] row_cells_i,
  output logic                 out_strobe_o,
  output logic [RowCellsW-1:0] out_row_cells_o,
  output logic [RowIndexW-1:0] out_row_index_o,
  output logic                 last_row_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [GenCountW-1:0] cfg_data_i
);

  logic [GenCountW-1:0] gen_count_q;
  lifet_cmd_t           cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_count_q <= GenCountW'(GenCountRst);
    end else if (cfg_valid_i && cfg_ready_o) begin
      gen_count_q <= cfg_data_i;
    end
  end

  lifet_ctrl #(
    .BOARD_HEIGHT(BOARD_HEIGHT)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .gen_count_i    (gen_count_q),
    .busy_o         (busy_o),
    .cmd_o          (cmd),
    .out_strobe_o   (out_strobe_o),
    .out_row_index_o(out_row_index_o),
    .last_row_o     (last_row_o)
  );

  lifet_datapath #(
    .BOARD_HEIGHT(BOARD_HEIGHT),
    .BOARD_WIDTH (BOARD_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .row_cells_i    (row_cells_i),
    .out_row_cells_o(out_row_cells_o)
  );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the toroidal Life engine: board loads, evolution and row emission.
`timescale 1ns / 1ps

module tb;
  import lifet_pkg::*;

  localparam int BoardRows  = 16;
  localparam int BoardCols  = 16;
  localparam int StallLimit = 20000;
  localparam int NumBoards  = 6;

  typedef enum int {
    PAT_ALL_LIVE,
    PAT_GLIDER,
    PAT_SPARSE,
    PAT_DENSE,
    PAT_NOISE
  } board_pattern_e;

  typedef struct packed {
    logic [RowCellsW-1:0] cells;
    logic [RowIndexW-1:0] index;
    logic                 last;
  } board_row_t;

  // Known expected value for a row, typed in where it is obvious
  typedef struct packed {
    logic                 known;
    logic [RowCellsW-1:0] cells;
  } row_hint_t;

  typedef struct packed {
    logic [RowCellsW-1:0] cells;
    logic                 known;
    logic [RowCellsW-1:0] want;
  } directed_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic [RowCellsW-1:0] row_cells_i = '0;
  logic                 out_strobe_o;
  logic [RowCellsW-1:0] out_row_cells_o;
  logic [RowIndexW-1:0] out_row_index_o;
  logic                 last_row_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [GenCountW-1:0] cfg_data_i = '0;

  // Zero generations: every row comes back as loaded
  directed_row_t directed_rows [BoardRows] = '{
    '{16'h0000, 1'b1, 16'h0000}, '{16'hFFFF, 1'b1, 16'hFFFF},
    '{16'h0001, 1'b1, 16'h0001}, '{16'h8000, 1'b1, 16'h8000},
    '{16'h8001, 1'b1, 16'h8001}, '{16'h5555, 1'b1, 16'h5555},
    '{16'hAAAA, 1'b1, 16'hAAAA}, '{16'h00FF, 1'b1, 16'h00FF},
    '{16'hFF00, 1'b1, 16'hFF00}, '{16'h0F0F, 1'b1, 16'h0F0F},
    '{16'hF0F0, 1'b1, 16'hF0F0}, '{16'h1234, 1'b1, 16'h1234},
    '{16'h7FFE, 1'b1, 16'h7FFE}, '{16'h0000, 1'b1, 16'h0000},
    '{16'hFFFF, 1'b1, 16'hFFFF}, '{16'h8421, 1'b1, 16'h8421}
  };

  logic [RowCellsW-1:0] life_board [BoardRows];
  logic [RowCellsW-1:0] next_board [BoardRows];
  row_hint_t            board_hints [BoardRows];
  int                   rows_loaded = 0;
  logic [GenCountW-1:0] gen_setting = GenCountW'(GenCountRst);

  board_row_t pending_rows [$];
  row_hint_t  hint_fifo [$];
  int         fail_count = 0;
  int         stall_cycles = 0;

  life_automaton_torus_unit #(
    .BOARD_HEIGHT(BoardRows),
    .BOARD_WIDTH (BoardCols)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .row_cells_i    (row_cells_i),
    .out_strobe_o   (out_strobe_o),
    .out_row_cells_o(out_row_cells_o),
    .out_row_index_o(out_row_index_o),
    .last_row_o     (last_row_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Advance the board one generation on the torus
  task automatic step_generation();
    int n;
    int rr;
    int cc;
    for (int r = 0; r < BoardRows; r++) begin
      for (int c = 0; c < BoardCols; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) begin
              rr = (r + BoardRows + dr) % BoardRows;
              cc = (c + BoardCols + dc) % BoardCols;
              n += life_board[rr][cc];
            end
          end
        end
        if (life_board[r][c])
          next_board[r][c] = (n == NbrSurviveLo) || (n == NbrBirth);
        else
          next_board[r][c] = (n == NbrBirth);
      end
    end
    for (int r = 0; r < BoardRows; r++) life_board[r] = next_board[r];
  endtask

  task automatic load_row(input logic [RowCellsW-1:0] cells, input row_hint_t hint);
    board_row_t res;
    life_board[rows_loaded] = cells;
    board_hints[rows_loaded] = hint;
    rows_loaded++;
    if (rows_loaded == BoardRows) begin
      rows_loaded = 0;
      for (int g = 0; g < gen_setting; g++) step_generation();
      for (int r = 0; r < BoardRows; r++) begin
        res.cells = board_hints[r].known ? board_hints[r].cells : life_board[r];
        res.index = RowIndexW'(r);
        res.last  = (r == BoardRows - 1);
        pending_rows.push_back(res);
      end
    end
  endtask

  task automatic check_row();
    board_row_t want;
    if (pending_rows.size() == 0) begin
      report_mismatch($sformatf("unexpected row %0d cells %h", out_row_index_o,
                                out_row_cells_o));
    end else begin
      want = pending_rows.pop_front();
      if (out_row_cells_o !== want.cells)
        report_mismatch($sformatf("row %0d cells %h, want %h", want.index,
                                  out_row_cells_o, want.cells));
      if (out_row_index_o !== want.index)
        report_mismatch($sformatf("row index %0d, want %0d", out_row_index_o, want.index));
      if (last_row_o !== want.last)
        report_mismatch($sformatf("row %0d last flag %b, want %b", want.index,
                                  last_row_o, want.last));
    end
  endtask

  // Sample both sides at the clock edge, before the block updates
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_strobe_o) check_row();
      if (start_i && !busy_o) load_row(row_cells_i, hint_fifo.pop_front());
      if (cfg_valid_i && cfg_ready_o) gen_setting = cfg_data_i;
      if (out_strobe_o || (start_i && !busy_o) || (cfg_valid_i && cfg_ready_o))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  initial begin
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("[life_automaton_torus_unit] ERROR");
    $finish;
  end

  task automatic send_row(input logic [RowCellsW-1:0] cells, input row_hint_t hint,
                          input int idle_pct);
    row_hint_t h;
    h = hint;
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    hint_fifo.push_back(h);
    start_i     <= 1'b1;
    row_cells_i <= cells;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic write_gen_count(input logic [GenCountW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold until every expected row has come out and the block is idle again
  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_rows.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [RowCellsW-1:0] pattern_row(input board_pattern_e pat, input int r);
    case (pat)
      PAT_ALL_LIVE: return '1;
      PAT_GLIDER: begin
        // glider straddling the wrap corner
        if (r == BoardRows - 1) return 16'h0001;
        if (r == 0) return 16'h0002;
        if (r == 1) return 16'h8003;
        return '0;
      end
      PAT_SPARSE: return RowCellsW'($urandom & $urandom & $urandom);
      PAT_DENSE:  return RowCellsW'($urandom | $urandom);
      default:    return RowCellsW'($urandom);
    endcase
  endfunction

  initial begin
    int             phase_idle [NumBoards] = '{0, 85, 33, 0, 85, 33};
    logic [7:0]     phase_gen [NumBoards];
    board_pattern_e pat;
    row_hint_t      no_hint;
    row_hint_t      hint;
    int             tail_rows;

    no_hint = '{known: 1'b0, cells: '0};
    phase_gen[0] = 8'd1;
    phase_gen[1] = 8'd255;
    phase_gen[2] = 8'($urandom_range(2, 40));
    phase_gen[3] = 8'd0;
    phase_gen[4] = 8'd2;
    phase_gen[5] = 8'($urandom_range(1, 255));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_gen_count(8'd0);
    foreach (directed_rows[i]) begin
      hint = '{known: directed_rows[i].known, cells: directed_rows[i].want};
      send_row(directed_rows[i].cells, hint, 0);
    end
    wait_drained();

    for (int b = 0; b < NumBoards; b++) begin
      write_gen_count(phase_gen[b]);
      pat = (b < 2) ? board_pattern_e'(b) : board_pattern_e'($urandom_range(0, 5));
      for (int r = 0; r < BoardRows; r++)
        send_row(pattern_row(pat, r), no_hint, phase_idle[b]);
      wait_drained();
    end

    // Partial board: must produce nothing
    tail_rows = $urandom_range(1, BoardRows - 1);
    for (int r = 0; r < tail_rows; r++)
      send_row(pattern_row(PAT_NOISE, r), no_hint, 33);
    start_i <= 1'b0;

    wait_drained();
    repeat (BoardRows * 4) @(posedge clk_i);
    if (fail_count == 0)
      $display("[life_automaton_torus_unit] OK");
    else
      $display("[life_automaton_torus_unit] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/lifet_pkg.sv
hw/rtl/lifet_datapath.sv
hw/rtl/lifet_ctrl.sv
hw/rtl/life_automaton_torus_unit.sv
tb/tb.sv
